FILE: design/nrr_pkg.sv
// Package for the nibble row realigner: shared types, constants and helpers.
`timescale 1ns / 1ps

package nrr_pkg;

    localparam int DIM_W        = 8;
    localparam int CFG_DATA_W   = 20;
    localparam int OFFSET_W     = 15;
    localparam int NIB_W        = 4;
    localparam int BYTE_W       = 8;
    localparam int DEF_MAX_DIM  = 255;
    localparam int DEF_ADDR_BITS = 20;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [NIB_W-1:0] NIB_MASK = 4'hf;
    localparam logic [NIB_W-1:0] NIB_PAD  = 4'h0;

    typedef enum logic [1:0] {
        REG_GLYPH_WIDTH  = 2'd0,
        REG_GLYPH_HEIGHT = 2'd1,
        REG_DEST_BASE    = 2'd2,
        REG_UNUSED       = 2'd3
    } t_reg_index;

    typedef struct packed {
        logic [NIB_W-1:0]    held_nibble;
        logic                held_valid;
        logic [DIM_W-1:0]    column_count;
        logic [DIM_W-1:0]    row_count;
        logic [OFFSET_W-1:0] byte_offset;
    } t_walk;

    typedef struct packed {
        t_walk               walk;
        logic                emit;
        logic [BYTE_W-1:0]   out_byte;
        logic [OFFSET_W-1:0] offset;
        logic                row_end;
        logic                glyph_end;
    } t_step;

    // Zero acts as one, values above the limit are clamped to it.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned max_dim);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (32'(v) > max_dim) begin
            r = DIM_W'(max_dim);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // One nibble through the row walker.
    function automatic t_step walk_nibble(input t_walk s, input logic [NIB_W-1:0] n,
                                          input logic [DIM_W-1:0] width,
                                          input logic [DIM_W-1:0] height);
        t_step            r;
        logic [DIM_W:0]   col1;
        logic [DIM_W:0]   row1;
        logic             row_done;
        col1     = {1'b0, s.column_count} + (DIM_W+1)'(1);
        row1     = {1'b0, s.row_count} + (DIM_W+1)'(1);
        row_done = col1 >= {1'b0, width};
        r        = '0;
        r.walk   = s;
        r.offset = s.byte_offset;
        r.walk.column_count = col1[DIM_W-1:0];
        if (s.held_valid || row_done) begin
            r.emit      = 1'b1;
            r.out_byte  = s.held_valid ? {s.held_nibble, n & NIB_MASK} : {n, NIB_PAD};
            r.row_end   = row_done;
            r.glyph_end = row_done && (row1 >= {1'b0, height});
            r.walk.byte_offset = s.byte_offset + OFFSET_W'(1);
            r.walk.held_valid  = 1'b0;
            r.walk.held_nibble = '0;
            if (row_done) begin
                r.walk.column_count = '0;
                r.walk.row_count    = row1[DIM_W-1:0];
            end
            if (r.glyph_end) begin
                r.walk.column_count = '0;
                r.walk.row_count    = '0;
                r.walk.byte_offset  = '0;
            end
        end else begin
            r.walk.held_nibble = n;
            r.walk.held_valid  = 1'b1;
        end
        return r;
    endfunction

endpackage

FILE: design/nrr_core.sv
// Realign core: walker state and the two-nibble step producing up to two results.
`timescale 1ns / 1ps

module nrr_core #(
    parameter int ADDR_BITS = nrr_pkg::DEF_ADDR_BITS,
    parameter int RES_W     = nrr_pkg::BYTE_W + ADDR_BITS + 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_fire,
    input  logic [nrr_pkg::BYTE_W-1:0]      i_byte,
    input  logic [nrr_pkg::DIM_W-1:0]       i_width,
    input  logic [nrr_pkg::DIM_W-1:0]       i_height,
    input  logic [nrr_pkg::CFG_DATA_W-1:0]  i_base,
    output logic [1:0]                      o_count,
    output logic [RES_W-1:0]                o_res0,
    output logic [RES_W-1:0]                o_res1
);
    import nrr_pkg::*;

    t_walk r_walk;
    t_walk n_walk;
    t_step s1;
    t_step s2;
    logic  emit2;
    logic [RES_W-1:0] res1;
    logic [RES_W-1:0] res2;

    function automatic logic [RES_W-1:0] pack_res(input t_step s,
                                                  input logic [CFG_DATA_W-1:0] base);
        logic [32:0] sum;
        sum = 33'(base) + 33'(s.offset);
        return {s.out_byte, sum[ADDR_BITS-1:0], s.row_end, s.glyph_end};
    endfunction

    always_comb begin
        s1     = walk_nibble(r_walk, i_byte[BYTE_W-1:NIB_W], i_width, i_height);
        s2     = walk_nibble(s1.walk, i_byte[NIB_W-1:0], i_width, i_height);
        emit2  = s2.emit && !s1.glyph_end;
        n_walk = s1.glyph_end ? s1.walk : s2.walk;
        res1   = pack_res(s1, i_base);
        res2   = pack_res(s2, i_base);
        o_count = 2'(s1.emit) + 2'(emit2);
        o_res0  = s1.emit ? res1 : res2;
        o_res1  = res2;
        if (!i_fire) begin
            o_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk <= '0;
        end else if (i_fire) begin
            r_walk <= n_walk;
        end
    end

endmodule

FILE: design/nrr_queue.sv
// Result queue: takes up to two results per cycle, delivers one per transfer.
`timescale 1ns / 1ps

module nrr_queue #(
    parameter int WIDTH = 30,
    parameter int DEPTH = nrr_pkg::QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [1:0]                 i_push_n,
    input  logic [WIDTH-1:0]           i_data0,
    input  logic [WIDTH-1:0]           i_data1,
    input  logic                       i_pop,
    output logic [$clog2(DEPTH+1)-1:0] o_count,
    output logic                       o_valid,
    output logic [WIDTH-1:0]           o_data
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] wr1;
    logic             pop_ok;

    assign wr1     = r_wr + PTR_W'(1);
    assign pop_ok  = i_pop && (r_count != '0);
    assign o_count = r_count;
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push_n != 2'd0) begin
            r_mem[r_wr] <= i_data0;
        end
        if (i_push_n == 2'd2) begin
            r_mem[wr1] <= i_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PTR_W'(i_push_n);
            r_rd    <= r_rd + PTR_W'(pop_ok);
            r_count <= r_count + CNT_W'(i_push_n) - CNT_W'(pop_ok);
        end
    end

endmodule

FILE: design/nibble_row_realigner.sv
// Top level of the nibble row realigner: config registers, input register, core, queue.
// Path: a source byte is held in the input register, then its results are written to the queue and leave it in order.
// Throughput: one source byte per cycle while each yields at most one byte and the output
// is not stalled; a byte that yields two bytes is limited by the one-result-per-cycle output.
// Reset (synchronous, active low): counters and queue empty, width 1, height 1, base 0.
`timescale 1ns / 1ps

module nibble_row_realigner #(
    parameter int MAX_DIM   = nrr_pkg::DEF_MAX_DIM,
    parameter int ADDR_BITS = nrr_pkg::DEF_ADDR_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [nrr_pkg::BYTE_W-1:0]      i_src_byte,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [nrr_pkg::BYTE_W-1:0]      o_out_byte,
    output logic [ADDR_BITS-1:0]            o_dest_address,
    output logic                            o_row_end,
    output logic                            o_glyph_end,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  nrr_pkg::t_reg_index             i_cfg_index,
    input  logic [nrr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import nrr_pkg::*;

    localparam int RES_W = BYTE_W + ADDR_BITS + 2;
    localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

    logic [DIM_W-1:0]      r_width;
    logic [DIM_W-1:0]      r_height;
    logic [CFG_DATA_W-1:0] r_base;
    logic                  r_in_valid;
    logic [BYTE_W-1:0]     r_in_byte;
    logic                  fire;
    logic                  room;
    logic [1:0]            push_n;
    logic [RES_W-1:0]      res0;
    logic [RES_W-1:0]      res1;
    logic [CNT_W-1:0]      q_count;
    logic [RES_W-1:0]      q_data;

    assign o_cfg_ready = 1'b1;
    assign room        = q_count <= CNT_W'(QUEUE_DEPTH - 2);
    assign fire        = r_in_valid && room;
    assign o_stall     = r_in_valid && !room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
            r_base   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_GLYPH_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                REG_GLYPH_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                REG_DEST_BASE:    r_base   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_src_byte;
        end
    end

    nrr_core #(
        .ADDR_BITS (ADDR_BITS),
        .RES_W     (RES_W)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_byte   (r_in_byte),
        .i_width  (eff_dim(r_width, MAX_DIM)),
        .i_height (eff_dim(r_height, MAX_DIM)),
        .i_base   (r_base),
        .o_count  (push_n),
        .o_res0   (res0),
        .o_res1   (res1)
    );

    nrr_queue #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_data0  (res0),
        .i_data1  (res1),
        .i_pop    (!i_stall),
        .o_count  (q_count),
        .o_valid  (o_valid),
        .o_data   (q_data)
    );

    assign o_out_byte     = q_data[RES_W-1 -: BYTE_W];
    assign o_dest_address = q_data[ADDR_BITS+1:2];
    assign o_row_end      = q_data[1];
    assign o_glyph_end    = q_data[0];

endmodule

FILE: sim/nibble_row_realigner_tb.sv
// Testbench for the nibble row realigner: random and directed glyph streams with a scoreboard.
`timescale 1ns / 1ps

module nibble_row_realigner_tb;
    import nrr_pkg::*;

    localparam int TOTAL_ITEMS    = 1320;
    localparam int DRAIN_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [BYTE_W-1:0]        pixels;
        logic [DEF_ADDR_BITS-1:0] addr;
        logic                     row_end;
        logic                     glyph_end;
    } t_aligned_byte;

    class aligned_byte_tracker;
        logic [DIM_W-1:0]         width_reg;
        logic [DIM_W-1:0]         height_reg;
        logic [DEF_ADDR_BITS-1:0] base_reg;
        logic [NIB_W-1:0]         held_nibble;
        bit                       held_valid;
        int unsigned              column_count;
        int unsigned              row_count;
        logic [OFFSET_W-1:0]      byte_offset;
        t_aligned_byte            due[$];
        int                       errors;
        int                       glyphs;

        function new();
            width_reg    = 8'd1;
            height_reg   = 8'd1;
            base_reg     = '0;
            held_nibble  = '0;
            held_valid   = 1'b0;
            column_count = 0;
            row_count    = 0;
            byte_offset  = '0;
            errors       = 0;
            glyphs       = 0;
        endfunction

        function int unsigned clamp_dim(input logic [DIM_W-1:0] v);
            if (v == '0) return 1;
            if (int'(v) > DEF_MAX_DIM) return DEF_MAX_DIM;
            return int'(v);
        endfunction

        function void write_reg(input t_reg_index idx, input logic [CFG_DATA_W-1:0] v);
            case (idx)
                REG_GLYPH_WIDTH:  width_reg  = v[DIM_W-1:0];
                REG_GLYPH_HEIGHT: height_reg = v[DIM_W-1:0];
                REG_DEST_BASE:    base_reg   = v[DEF_ADDR_BITS-1:0];
                default: ;
            endcase
        endfunction

        // Returns 1 when the glyph closes, so the rest of the source byte is dropped.
        function bit place_nibble(input logic [NIB_W-1:0] n);
            bit            row_done;
            bit            glyph_done;
            t_aligned_byte item;
            column_count = column_count + 1;
            row_done     = column_count >= clamp_dim(width_reg);
            if (!held_valid && !row_done) begin
                held_nibble = n;
                held_valid  = 1'b1;
                return 1'b0;
            end
            glyph_done     = row_done && (row_count + 1 >= clamp_dim(height_reg));
            item.pixels    = held_valid ? {held_nibble, n} : {n, NIB_PAD};
            item.addr      = base_reg + DEF_ADDR_BITS'(byte_offset);
            item.row_end   = row_done;
            item.glyph_end = glyph_done;
            due.push_back(item);
            byte_offset = byte_offset + OFFSET_W'(1);
            held_valid  = 1'b0;
            held_nibble = '0;
            if (row_done) begin
                column_count = 0;
                row_count    = row_count + 1;
            end
            if (glyph_done) begin
                column_count = 0;
                row_count    = 0;
                byte_offset  = '0;
            end
            return glyph_done;
        endfunction

        function void take_source_byte(input logic [BYTE_W-1:0] src);
            if (!place_nibble(src[7:4])) begin
                void'(place_nibble(src[3:0]));
            end
        endfunction

        function void match_aligned_byte(input t_aligned_byte got);
            t_aligned_byte want;
            if (due.size() == 0) begin
                errors++;
                $display("%0t: unexpected transfer, got byte %h addr %h row_end %b glyph_end %b",
                         $time, got.pixels, got.addr, got.row_end, got.glyph_end);
                return;
            end
            want = due.pop_front();
            if (want.glyph_end) glyphs++;
            if (got !== want) begin
                errors++;
                $display("%0t: expected byte %h addr %h row_end %b glyph_end %b",
                         $time, want.pixels, want.addr, want.row_end, want.glyph_end);
                $display("%0t: got      byte %h addr %h row_end %b glyph_end %b",
                         $time, got.pixels, got.addr, got.row_end, got.glyph_end);
            end
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_valid     = 1'b0;
    logic [BYTE_W-1:0]        i_src_byte  = '0;
    logic                     i_stall     = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    t_reg_index               i_cfg_index = REG_GLYPH_WIDTH;
    logic [CFG_DATA_W-1:0]    i_cfg_data  = '0;
    logic                     o_stall;
    logic                     o_valid;
    logic [BYTE_W-1:0]        o_out_byte;
    logic [DEF_ADDR_BITS-1:0] o_dest_address;
    logic                     o_row_end;
    logic                     o_glyph_end;
    logic                     o_cfg_ready;

    aligned_byte_tracker board;
    bit  idle_on = 1'b1;
    int  bytes_sent = 0;
    int  bytes_seen = 0;
    int  cfg_writes = 0;
    int  quiet_cycles = 0;

    nibble_row_realigner u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_src_byte     (i_src_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_dest_address (o_dest_address),
        .o_row_end      (o_row_end),
        .o_glyph_end    (o_glyph_end),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_stall <= idle_on && ($urandom_range(99) < 28);
    end

    // Handshakes are sampled mid-cycle; the transfer lands at the next rising edge.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                board.match_aligned_byte({o_out_byte, o_dest_address, o_row_end, o_glyph_end});
                bytes_seen++;
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                    $display("simulation failed");
                    $finish;
                end
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        bit taken;
        while (idle_on && $urandom_range(99) < 28) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_src_byte <= b;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        board.take_source_byte(b);
        bytes_sent++;
    endtask

    task automatic configure(input logic [3:0] sel, input logic [DIM_W-1:0] w,
                             input logic [DIM_W-1:0] h, input logic [DEF_ADDR_BITS-1:0] base);
        t_reg_index            idx;
        logic [CFG_DATA_W-1:0] val;
        bit                    taken;
        idx = idx.first();
        repeat (idx.num()) begin
            if (sel[idx]) begin
                case (idx)
                    REG_GLYPH_WIDTH:  val = {12'($urandom), w};
                    REG_GLYPH_HEIGHT: val = {12'($urandom), h};
                    REG_DEST_BASE:    val = base;
                    default:          val = CFG_DATA_W'($urandom);
                endcase
                i_cfg_valid <= 1'b1;
                i_cfg_index <= idx;
                i_cfg_data  <= val;
                do begin
                    @(negedge i_clk);
                    taken = o_cfg_ready;
                    @(posedge i_clk);
                end while (!taken);
                board.write_reg(idx, val);
                cfg_writes++;
            end
            idx = idx.next();
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_for_idle();
        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [DIM_W-1:0]         w;
        logic [DIM_W-1:0]         h;
        logic [DEF_ADDR_BITS-1:0] base;
        logic [3:0]               sel;
        int                       phase_len;
        int                       phase;
        board = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset sizes: every byte closes a glyph and its low nibble is dropped.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hA5);
        wait_for_idle();

        // Odd width pads rows; base near the top wraps the address.
        configure(4'b0111, 8'd3, 8'd2, 20'hFFFFE);
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(8'h56);
        send_byte(8'h78);
        send_byte(8'hFF);
        send_byte(8'h00);
        wait_for_idle();

        // Zero sizes act as one; the unused index is ignored.
        configure(4'b1011, 8'd0, 8'd0, '0);
        send_byte(8'h5A);
        send_byte(8'hC3);
        wait_for_idle();

        // Even width passes bytes through.
        configure(4'b0111, 8'd2, 8'd3, 20'h00010);
        send_byte(8'h01);
        send_byte(8'h23);
        send_byte(8'h45);
        send_byte(8'h67);
        wait_for_idle();

        // Largest sizes, then shrink the width and height mid-glyph.
        configure(4'b0111, 8'd255, 8'd255, 20'h12345);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h96);
        wait_for_idle();
        configure(4'b0001, 8'd1, 8'd255, '0);
        send_byte(8'h3C);
        send_byte(8'hE7);
        wait_for_idle();
        configure(4'b0010, 8'd1, 8'd1, '0);
        send_byte(8'h81);
        wait_for_idle();

        phase = 0;
        while (bytes_sent < TOTAL_ITEMS) begin
            case ($urandom_range(9))
                0:       w = 8'd0;
                1:       w = 8'd1;
                2:       w = 8'd255;
                3:       w = 8'd2;
                default: w = 8'($urandom_range(16, 1));
            endcase
            case ($urandom_range(9))
                0:       h = 8'd0;
                1:       h = 8'd1;
                2:       h = 8'd255;
                default: h = 8'($urandom_range(6, 1));
            endcase
            case ($urandom_range(5))
                0:       base = '0;
                1:       base = 20'hFFFFF;
                2:       base = 20'hFFFFF - 20'($urandom_range(40));
                default: base = 20'($urandom);
            endcase
            sel = 4'($urandom);
            if ($urandom_range(3) != 0) sel[2:0] = 3'b111;
            configure(sel, w, h, base);

            idle_on   = (phase != 4);
            phase_len = (w >= 8'd100) ? $urandom_range(300, 130) : $urandom_range(90, 20);
            if (phase == 4) phase_len = 200;
            if (phase_len > TOTAL_ITEMS - bytes_sent) phase_len = TOTAL_ITEMS - bytes_sent;
            repeat (phase_len) begin
                if ($urandom_range(7) == 0)
                    send_byte($urandom_range(1) ? 8'hFF : 8'h00);
                else
                    send_byte(8'($urandom));
            end
            wait_for_idle();
            idle_on = 1'b1;
            phase++;
        end

        board.errors += board.pending();
        $display("Sent %0d source bytes over %0d phases, checked %0d aligned bytes, %0d glyphs.",
                 bytes_sent, phase, bytes_seen, board.glyphs);
        $display("Made %0d register writes: zero, one and full sizes, bases at both ends.",
                 cfg_writes);
        if (board.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
